>>> design/nads_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types for the nesting-aware delimiter splitter.
// Used by every module of the design; depends on nothing.
package nads_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int OFFSET_BITS = 16;

  localparam int LEVEL_W   = $clog2(STACK_DEPTH + 1);
  localparam int OFS_EXT_W = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;
  localparam int LVL_EXT_W = (LEVEL_W > 6) ? LEVEL_W : 6;

  localparam logic [7:0] DELIM_RESET = 8'd59;

  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;

  localparam logic [1:0] CL_PAREN   = 2'd0;
  localparam logic [1:0] CL_BRACE   = 2'd1;
  localparam logic [1:0] CL_BRACKET = 2'd2;
  localparam logic [1:0] CL_QUOTE   = 2'd3;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [1:0] code;
  } stack_op_t;

  typedef struct packed {
    logic        split;
    logic [15:0] offset;
    logic [5:0]  depth;
    logic        unclosed_error;
    logic        tail_present;
    logic        overflow;
  } result_t;

endpackage

>>> design/nads_cell.sv
`timescale 1ns / 1ps
// One entry of the closer stack: holds a closer code and shifts it toward
// or away from the top together with its neighbors. Depends on nads_pkg.
module nads_cell (
  input  logic                clk,
  input  nads_pkg::stack_op_t op,
  input  logic [1:0]          from_upper,
  input  logic [1:0]          from_lower,
  output logic [1:0]          value
);

  logic [1:0] value_r;
  logic [1:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    if (op.push) begin
      value_nxt = from_upper;
    end else if (op.pop) begin
      value_nxt = from_lower;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

>>> design/nads_stack.sv
`timescale 1ns / 1ps
// Closer stack built as a row of shifting cells; cell zero is the top.
// Depends on nads_pkg and nads_cell.
module nads_stack (
  input  logic                clk,
  input  nads_pkg::stack_op_t op,
  output logic [1:0]          top
);

  logic [1:0] cell_q [nads_pkg::STACK_DEPTH];

  for (genvar i = 0; i < nads_pkg::STACK_DEPTH; i++) begin : g_cell
    logic [1:0] upper;
    logic [1:0] lower;
    if (i == 0) begin : g_first
      assign upper = op.code;
    end else begin : g_mid
      assign upper = cell_q[i-1];
    end
    if (i == nads_pkg::STACK_DEPTH - 1) begin : g_last
      assign lower = nads_pkg::CL_PAREN;
    end else begin : g_inner
      assign lower = cell_q[i+1];
    end
    nads_cell u_cell (
      .clk        (clk),
      .op         (op),
      .from_upper (upper),
      .from_lower (lower),
      .value      (cell_q[i])
    );
  end

  assign top = cell_q[0];

endmodule

>>> design/nesting_aware_delimiter_splitter_top.sv
`timescale 1ns / 1ps
// Top level of the nesting-aware delimiter splitter: character decode, level
// and offset counters, and the output skid buffer. Depends on nads_pkg, nads_stack.
// Results are registered in the output or skid register. Throughput: one
// character per cycle while the skid register is empty, set by the stack shift.
// A two-entry output buffer keeps input flowing for one stalled result.
// Reset (synchronous, active low) clears counters, flags and buffers and sets
// the delimiter to ';'; stack cells are not reset. No clearing pass is needed.
module nesting_aware_delimiter_splitter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_split,
  output logic [15:0] out_offset,
  output logic [5:0]  out_depth,
  output logic        out_unclosed_error,
  output logic        out_tail_present,
  output logic        out_overflow,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_delimiter
);

  localparam int LW = nads_pkg::LEVEL_W;
  localparam int OW = nads_pkg::OFFSET_BITS;

  logic [7:0]    delim_r;
  logic [LW-1:0] level_r, level_nxt;
  logic          esc_r, esc_nxt;
  logic          ovf_r, ovf_nxt;
  logic [OW-1:0] offset_r, offset_nxt;

  logic                 out_valid_r, skid_valid_r;
  nads_pkg::result_t    out_r, skid_r, res;
  nads_pkg::stack_op_t  op;

  logic       in_acc;
  logic [1:0] top;
  logic       top_valid, in_str, split, want_push, do_push, do_pop;
  logic [1:0] push_code;
  logic [nads_pkg::OFS_EXT_W-1:0] pos_ext;
  logic [nads_pkg::LVL_EXT_W-1:0] lvl_ext;

  assign in_ready  = !skid_valid_r;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  nads_stack u_stack (
    .clk (clk),
    .op  (op),
    .top (top)
  );

  assign top_valid = (level_r != '0);
  assign in_str    = top_valid && (top == nads_pkg::CL_QUOTE);

  always_comb begin
    split     = 1'b0;
    want_push = 1'b0;
    push_code = nads_pkg::CL_PAREN;
    do_pop    = 1'b0;
    esc_nxt   = esc_r;
    if (in_str) begin
      if (esc_r) begin
        esc_nxt = 1'b0;
      end else if (in_ch == nads_pkg::CH_QUOTE) begin
        do_pop = 1'b1;
      end else if (in_ch == nads_pkg::CH_BSLASH) begin
        esc_nxt = 1'b1;
      end
    end else if (!top_valid && delim_r != 8'd0 && in_ch == delim_r) begin
      split = 1'b1;
    end else begin
      case (in_ch)
        nads_pkg::CH_RPAREN:   do_pop = top_valid && (top == nads_pkg::CL_PAREN);
        nads_pkg::CH_RBRACE:   do_pop = top_valid && (top == nads_pkg::CL_BRACE);
        nads_pkg::CH_RBRACKET: do_pop = top_valid && (top == nads_pkg::CL_BRACKET);
        nads_pkg::CH_LPAREN: begin
          want_push = 1'b1;
          push_code = nads_pkg::CL_PAREN;
        end
        nads_pkg::CH_LBRACE: begin
          want_push = 1'b1;
          push_code = nads_pkg::CL_BRACE;
        end
        nads_pkg::CH_LBRACKET: begin
          want_push = 1'b1;
          push_code = nads_pkg::CL_BRACKET;
        end
        nads_pkg::CH_QUOTE: begin
          want_push = 1'b1;
          push_code = nads_pkg::CL_QUOTE;
        end
        default: ;
      endcase
    end
    do_push = want_push && (level_r < LW'(nads_pkg::STACK_DEPTH));
    ovf_nxt = ovf_r || (want_push && !do_push);
    if (do_push) begin
      level_nxt = level_r + LW'(1);
    end else if (do_pop) begin
      level_nxt = level_r - LW'(1);
    end else begin
      level_nxt = level_r;
    end
    if (split) begin
      offset_nxt = '0;
    end else if (offset_r != {OW{1'b1}}) begin
      offset_nxt = offset_r + OW'(1);
    end else begin
      offset_nxt = offset_r;
    end
  end

  assign op.push = in_acc && do_push;
  assign op.pop  = in_acc && do_pop;
  assign op.code = push_code;

  always_comb begin
    pos_ext            = nads_pkg::OFS_EXT_W'(offset_r);
    lvl_ext            = nads_pkg::LVL_EXT_W'(level_nxt);
    res.split          = split;
    res.offset         = (pos_ext > nads_pkg::OFS_EXT_W'(16'hFFFF)) ? 16'hFFFF : pos_ext[15:0];
    res.depth          = (lvl_ext > nads_pkg::LVL_EXT_W'(63)) ? 6'd63 : lvl_ext[5:0];
    res.unclosed_error = in_last && (level_nxt != '0);
    res.tail_present   = in_last && !split;
    res.overflow       = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r  <= nads_pkg::DELIM_RESET;
      level_r  <= '0;
      esc_r    <= 1'b0;
      ovf_r    <= 1'b0;
      offset_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        delim_r <= cfg_delimiter;
      end
      if (in_acc) begin
        if (in_last) begin
          level_r  <= '0;
          esc_r    <= 1'b0;
          ovf_r    <= 1'b0;
          offset_r <= '0;
        end else begin
          level_r  <= level_nxt;
          esc_r    <= esc_nxt;
          ovf_r    <= ovf_nxt;
          offset_r <= offset_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (in_acc) begin
      skid_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_split          = out_r.split;
  assign out_offset         = out_r.offset;
  assign out_depth          = out_r.depth;
  assign out_unclosed_error = out_r.unclosed_error;
  assign out_tail_present   = out_r.tail_present;
  assign out_overflow       = out_r.overflow;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a pending output");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LW'(nads_pkg::STACK_DEPTH))
    else $error("stack level beyond stack depth");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last) |=> (level_r == '0 && !ovf_r && !esc_r && offset_r == '0))
    else $error("state not cleared after last character");

  a_split_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.split) |-> (out_r.depth == 6'd0))
    else $error("split reported at nonzero depth");

endmodule
